/* rtl/sgg_pkg.sv */
// Shared types, constants and helper functions for the subvoxel grid point generator.
// Depends on nothing; every other file in rtl/ imports it.
package sgg_pkg;

  localparam int MAX_PER_AXIS = 16;
  localparam int CNT_W        = 5;
  localparam int RES_W        = 31;
  localparam int COORD_W      = 32;
  localparam int IDX_W        = 12;
  localparam int TOTAL_W      = IDX_W + 1;
  localparam int POS_W        = $clog2(MAX_PER_AXIS);

  // reciprocal multiply for index / count, exact for IDX_W-bit dividends
  localparam int RCP_SH = 17;
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PRD_W  = IDX_W + RCP_W;

  // offset magnitude |2p+1-n| * res and its long division by 2n
  localparam int KABS_W     = CNT_W;
  localparam int MAG_W      = KABS_W + RES_W;
  localparam int DIV_D_W    = CNT_W + 1;
  localparam int REM_W      = DIV_D_W;
  localparam int DIV_STEPS  = 6;
  localparam int DIV_STAGES = MAG_W / DIV_STEPS;
  localparam int OFF_W      = MAG_W + 2;

  // pipeline stage numbers
  localparam int IDX_ST    = 4;
  localparam int MUL_ST    = IDX_ST + 1;
  localparam int DIV_FIRST = MUL_ST + 1;
  localparam int DIV_LAST  = MUL_ST + DIV_STAGES;
  localparam int NUM_ST    = DIV_LAST + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RES_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Z   = 3'd5;

  localparam logic [CNT_W-1:0] COUNT_RST = 5'd1;
  localparam logic [RES_W-1:0] RES_RST   = 31'd65536;

  typedef struct packed {
    logic [CNT_W-1:0]   nx;
    logic [CNT_W-1:0]   ny;
    logic [CNT_W-1:0]   nz;
    logic [RES_W-1:0]   rx;
    logic [RES_W-1:0]   ry;
    logic [RES_W-1:0]   rz;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    eff_count = (c > CNT_W'(MAX_PER_AXIS)) ? CNT_W'(MAX_PER_AXIS) : c;
  endfunction

  // ceil(2^RCP_SH / n); zero count gives zero (index is out of grid then)
  function automatic logic [RCP_W-1:0] rcp(input logic [CNT_W-1:0] n);
    case (n)
      5'd1:    rcp = 18'd131072;
      5'd2:    rcp = 18'd65536;
      5'd3:    rcp = 18'd43691;
      5'd4:    rcp = 18'd32768;
      5'd5:    rcp = 18'd26215;
      5'd6:    rcp = 18'd21846;
      5'd7:    rcp = 18'd18725;
      5'd8:    rcp = 18'd16384;
      5'd9:    rcp = 18'd14564;
      5'd10:   rcp = 18'd13108;
      5'd11:   rcp = 18'd11916;
      5'd12:   rcp = 18'd10923;
      5'd13:   rcp = 18'd10083;
      5'd14:   rcp = 18'd9363;
      5'd15:   rcp = 18'd8739;
      5'd16:   rcp = 18'd8192;
      default: rcp = '0;
    endcase
  endfunction

endpackage

/* rtl/sgg_cfg.sv */
// Configuration register file: grid counts and voxel sizes, plus derived grid size.
// Depends on sgg_pkg.
module sgg_cfg
  import sgg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CNT_W-1:0] cnt_x_r, cnt_y_r, cnt_z_r;
  logic [RES_W-1:0] res_x_r, res_y_r, res_z_r;
  logic [2*CNT_W-1:0] nxy;
  logic [3*CNT_W-1:0] tot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_x_r <= COUNT_RST;
      cnt_y_r <= COUNT_RST;
      cnt_z_r <= COUNT_RST;
      res_x_r <= RES_RST;
      res_y_r <= RES_RST;
      res_z_r <= RES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNT_X: cnt_x_r <= cfg_data[CNT_W-1:0];
        REG_COUNT_Y: cnt_y_r <= cfg_data[CNT_W-1:0];
        REG_COUNT_Z: cnt_z_r <= cfg_data[CNT_W-1:0];
        REG_RES_X:   res_x_r <= cfg_data[RES_W-1:0];
        REG_RES_Y:   res_y_r <= cfg_data[RES_W-1:0];
        REG_RES_Z:   res_z_r <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.nx    = eff_count(cnt_x_r);
    cfg.ny    = eff_count(cnt_y_r);
    cfg.nz    = eff_count(cnt_z_r);
    cfg.rx    = res_x_r;
    cfg.ry    = res_y_r;
    cfg.rz    = res_z_r;
    nxy       = (2*CNT_W)'(cfg.nx) * (2*CNT_W)'(cfg.ny);
    tot       = (3*CNT_W)'(nxy) * (3*CNT_W)'(cfg.nz);
    cfg.total = tot[TOTAL_W-1:0];
  end

endmodule

/* rtl/sgg_index.sv */
// Index splitter: point index into x/y/z grid positions and the out-of-grid flag.
// Four stages, reciprocal multiply then remainder. Depends on sgg_pkg.
module sgg_index
  import sgg_pkg::*;
(
  input  logic             clk,
  input  logic [NUM_ST:1]  en,
  input  cfg_t             cfg,
  input  logic [IDX_W-1:0] idx,
  output logic [POS_W-1:0] px,
  output logic [POS_W-1:0] py,
  output logic [POS_W-1:0] pz,
  output logic             err
);

  logic [IDX_W-1:0] s1_idx_r;
  logic [PRD_W-1:0] s1_prod_r;
  logic             s1_err_r;
  logic [IDX_W-1:0] s2_qx_r;
  logic [POS_W-1:0] s2_px_r;
  logic             s2_err_r;
  logic [IDX_W-1:0] s3_qx_r;
  logic [PRD_W-1:0] s3_prod_r;
  logic [POS_W-1:0] s3_px_r;
  logic             s3_err_r;
  logic [POS_W-1:0] s4_px_r, s4_py_r, s4_pz_r;
  logic             s4_err_r;

  logic [PRD_W-1:0] s1_prod_nxt, s3_prod_nxt;
  logic [IDX_W-1:0] qx, qy, rx_full, ry_full;

  always_comb begin
    s1_prod_nxt = PRD_W'(idx) * PRD_W'(rcp(cfg.nx));
    qx          = s1_prod_r[RCP_SH +: IDX_W];
    rx_full     = s1_idx_r - IDX_W'(qx * IDX_W'(cfg.nx));
    s3_prod_nxt = PRD_W'(s2_qx_r) * PRD_W'(rcp(cfg.ny));
    qy          = s3_prod_r[RCP_SH +: IDX_W];
    ry_full     = s3_qx_r - IDX_W'(qy * IDX_W'(cfg.ny));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_idx_r  <= idx;
      s1_prod_r <= s1_prod_nxt;
      s1_err_r  <= ({1'b0, idx} >= cfg.total);
    end
    if (en[2]) begin
      s2_qx_r  <= qx;
      s2_px_r  <= rx_full[POS_W-1:0];
      s2_err_r <= s1_err_r;
    end
    if (en[3]) begin
      s3_qx_r   <= s2_qx_r;
      s3_prod_r <= s3_prod_nxt;
      s3_px_r   <= s2_px_r;
      s3_err_r  <= s2_err_r;
    end
    if (en[IDX_ST]) begin
      s4_px_r  <= s3_px_r;
      s4_py_r  <= ry_full[POS_W-1:0];
      s4_pz_r  <= qy[POS_W-1:0];
      s4_err_r <= s3_err_r;
    end
  end

  assign px  = s4_px_r;
  assign py  = s4_py_r;
  assign pz  = s4_pz_r;
  assign err = s4_err_r;

endmodule

/* rtl/sgg_axis.sv */
// One coordinate lane: offset multiply, pipelined long division by 2n, saturating add.
// Carries the origin from entry to the adder. Depends on sgg_pkg.
module sgg_axis
  import sgg_pkg::*;
(
  input  logic                      clk,
  input  logic [NUM_ST:1]           en,
  input  logic [CNT_W-1:0]          n,
  input  logic [RES_W-1:0]          res,
  input  logic signed [COORD_W-1:0] origin,
  input  logic [POS_W-1:0]          p,
  input  logic                      err,
  output logic signed [COORD_W-1:0] dest,
  output logic                      dest_err
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] work;
  } div_t;

  function automatic div_t div_steps(input div_t s, input logic [DIV_D_W-1:0] d);
    div_t             r;
    logic [REM_W:0]   t;
    r = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {r.rem, r.work[MAG_W-1]};
      r.work = {r.work[MAG_W-2:0], 1'b0};
      if (t >= (REM_W+1)'(d)) begin
        t         = t - (REM_W+1)'(d);
        r.work[0] = 1'b1;
      end
      r.rem = t[REM_W-1:0];
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0] org_r [1:DIV_LAST];
  div_t                      dv_r  [MUL_ST:DIV_LAST];
  logic                      neg_r [MUL_ST:DIV_LAST];
  logic                      err_r [MUL_ST:DIV_LAST];
  logic signed [COORD_W-1:0] dest_r;
  logic                      dest_err_r;

  logic signed [CNT_W+1:0]   k;
  logic [CNT_W+1:0]          kabs;
  logic [DIV_D_W-1:0]        d;
  div_t                      mul_nxt;
  div_t                      dv_nxt [DIV_FIRST:DIV_LAST];
  logic signed [OFF_W-1:0]   off, sum;
  logic signed [COORD_W-1:0] dest_nxt;

  always_comb begin
    k             = $signed({2'b00, p, 1'b1}) - $signed({2'b00, n});
    kabs          = k[CNT_W+1] ? (CNT_W+2)'(-k) : k;
    mul_nxt.rem   = '0;
    mul_nxt.work  = MAG_W'(kabs[KABS_W-1:0]) * MAG_W'(res);
    d             = {n, 1'b0};
    for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
      dv_nxt[s] = div_steps(dv_r[s-1], d);
    end
    off = neg_r[DIV_LAST] ? -$signed({2'b00, dv_r[DIV_LAST].work})
                          :  $signed({2'b00, dv_r[DIV_LAST].work});
    sum = OFF_W'(org_r[DIV_LAST]) + off;
    // clamp to the signed coordinate range
    if (sum[OFF_W-1:COORD_W-1] != {(OFF_W-COORD_W+1){sum[OFF_W-1]}}) begin
      dest_nxt = sum[OFF_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                              : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      dest_nxt = sum[COORD_W-1:0];
    end
    if (err_r[DIV_LAST]) begin
      dest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      org_r[1] <= origin;
    end
    for (int s = 2; s <= DIV_LAST; s++) begin
      if (en[s]) begin
        org_r[s] <= org_r[s-1];
      end
    end
    if (en[MUL_ST]) begin
      dv_r[MUL_ST]  <= mul_nxt;
      neg_r[MUL_ST] <= k[CNT_W+1];
      err_r[MUL_ST] <= err;
    end
    for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
      if (en[s]) begin
        dv_r[s]  <= dv_nxt[s];
        neg_r[s] <= neg_r[s-1];
        err_r[s] <= err_r[s-1];
      end
    end
    if (en[NUM_ST]) begin
      dest_r     <= dest_nxt;
      dest_err_r <= err_r[DIV_LAST];
    end
  end

  assign dest     = dest_r;
  assign dest_err = dest_err_r;

endmodule

/* rtl/subvoxel_grid_point_generator.sv */
// Subvoxel grid point generator: turns a voxel origin and sample index into a point.
// Top level; instantiates sgg_cfg, sgg_index and three sgg_axis lanes. Depends on sgg_pkg.
//
// Usage:
//   in_*   : one beat per sample request: origins and point index in in_tdata.
//   out_*  : one beat per request, in order: dest_x/y/z in out_tdata and the
//            out-of-grid flag in out_tuser (coordinates read zero when it is set).
//   cfg_*  : register writes (index 0..5: count x/y/z, res x/y/z), always ready;
//            write only while the pipeline is empty.
// Throughput is one beat per cycle while the receiver is ready. From input beat to
// output beat: 4 stages split the index (reciprocal multiply and remainder for
// x, then y), 1 stage forms |2p+1-n|*res, 6 stages divide by 2n at 6 quotient bits
// each, and the last stage applies sign, adds and saturates into the output
// register.
// Each stage carries a valid bit and holds while the stage after it is full and
// stalled, so bubbles close up and in_tready stays high until every stage is full
// behind a stalled receiver. Nothing is dropped or repeated under stall.
// Synchronous reset empties the pipeline and loads counts of 1 and sizes of 1.0.
module subvoxel_grid_point_generator
  import sgg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] origin_x, [63:32] origin_y, [95:64] origin_z, [107:96] point_index, pad
  input  logic [111:0]          in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] dest_x, [63:32] dest_y, [95:64] dest_z
  output logic [95:0]           out_tdata,
  // [0] index_error
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic [NUM_ST:1]   v_r;
  logic [NUM_ST:1]   en;
  logic [NUM_ST-1:0] vin;
  logic [POS_W-1:0]  px, py, pz;
  logic              ierr;
  logic signed [COORD_W-1:0] dx, dy, dz;
  logic              ex;

  sgg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage advances when empty or when the next one advances
  always_comb begin
    en[NUM_ST] = !v_r[NUM_ST] || out_tready;
    for (int i = NUM_ST - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    vin = {v_r[NUM_ST-1:1], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 1; i <= NUM_ST; i++) begin
        if (en[i]) begin
          v_r[i] <= vin[i-1];
        end
      end
    end
  end

  sgg_index u_index (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .idx (in_tdata[107:96]),
    .px  (px),
    .py  (py),
    .pz  (pz),
    .err (ierr)
  );

  sgg_axis u_axis_x (
    .clk      (clk),
    .en       (en),
    .n        (cfg.nx),
    .res      (cfg.rx),
    .origin   (in_tdata[31:0]),
    .p        (px),
    .err      (ierr),
    .dest     (dx),
    .dest_err (ex)
  );

  sgg_axis u_axis_y (
    .clk      (clk),
    .en       (en),
    .n        (cfg.ny),
    .res      (cfg.ry),
    .origin   (in_tdata[63:32]),
    .p        (py),
    .err      (ierr),
    .dest     (dy),
    .dest_err ()
  );

  sgg_axis u_axis_z (
    .clk      (clk),
    .en       (en),
    .n        (cfg.nz),
    .res      (cfg.rz),
    .origin   (in_tdata[95:64]),
    .p        (pz),
    .err      (ierr),
    .dest     (dz),
    .dest_err ()
  );

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NUM_ST];
  assign out_tdata  = {dz, dy, dx};
  assign out_tuser  = ex;

endmodule
